FILE: sv/indexed_list_insert_erase_unit_macros.svh
// Assertion helpers for the indexed list block.
// Compiled out when SYNTH is defined.
`ifndef INDEXED_LIST_INSERT_ERASE_UNIT_MACROS_SVH
`define INDEXED_LIST_INSERT_ERASE_UNIT_MACROS_SVH

`ifndef SYNTH

// Expression must hold at every clock edge out of reset
`define ILIE_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ILIE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ILIE_ASSERT_ALWAYS(label, clk, rstn, expr, msg)
`define ILIE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: sv/ilie_pkg.sv
`default_nettype none

package ilie_pkg;

    // Field widths of the request and result
    localparam int KIND_BITS   = 2;
    localparam int POS_BITS    = 7;
    localparam int VALUE_BITS  = 32;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 7;

    // Packed stream widths, rounded up to whole bytes
    localparam int S_TDATA_BITS = 40;
    localparam int M_TDATA_BITS = 48;

    // Defaults for the top-level parameters
    localparam int DEF_CAPACITY     = 64;
    localparam int DEF_ELEMENT_BITS = 32;

    // Broadcast index width: covers a count of up to 2047 entries
    localparam int TGT_BITS = 11;

    // Cells per first-level group of the read-out OR tree
    localparam int GROUP_SIZE = 8;

    // Request kinds
    localparam logic [KIND_BITS-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_READ   = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_REMOVE = 2'd3;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;

    // Cell operations broadcast along the chain
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // Control broadcast to every cell
    typedef struct packed {
        logic [1:0]          op;
        logic [TGT_BITS-1:0] target;
    } ctl_t;

endpackage

`default_nettype wire

FILE: sv/ilie_cell.sv
`default_nettype none

// One list slot: holds entry INDEX, shifts with its neighbours
module ilie_cell import ilie_pkg::*; #(
    parameter int WIDTH = DEF_ELEMENT_BITS,
    parameter int INDEX = 0
) (
    input  wire logic             aclk,
    input  wire ctl_t             ctl,
    input  wire logic [WIDTH-1:0] wval,
    input  wire logic [WIDTH-1:0] lower_val,
    input  wire logic [WIDTH-1:0] upper_val,
    output logic      [WIDTH-1:0] entry,
    output logic      [WIDTH-1:0] rd_val
);

    logic [WIDTH-1:0] entry_reg;
    logic [WIDTH-1:0] entry_next;
    logic             hit;
    logic             above;

    assign hit   = (ctl.target == TGT_BITS'(INDEX));
    assign above = (ctl.target <  TGT_BITS'(INDEX));

    // insert: above <- lower, hit <- wval; remove: hit and above <- upper
    always_comb begin
        entry_next = entry_reg;
        case (ctl.op)
            OP_INSERT: begin
                if (above) begin
                    entry_next = lower_val;
                end else if (hit) begin
                    entry_next = wval;
                end
            end
            OP_REMOVE: begin
                if (hit || above) begin
                    entry_next = upper_val;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry  = entry_reg;
    // gated read-out, OR-combined upstream
    assign rd_val = ((ctl.op == OP_READ) && hit) ? entry_reg : '0;

endmodule

`default_nettype wire

FILE: sv/indexed_list_insert_erase_unit.sv
// Indexed list insert/erase unit.
// Keeps an ordered list of up to CAPACITY signed values in a row of cells.
// Input stream s_*: tuser carries the request kind (append, insert, read,
// remove), tdata the position and the value. Output stream m_*: one result
// per request with the read value, status, element count and empty flag.
// A request is decided and applied to all cells in the cycle it is accepted:
// an insert or remove shifts every later cell at once, so one request per
// cycle is sustained while the output is not stalled. The read value passes
// through a two-level OR tree (groups of 8 cells, first level registered),
// so a result is held in the group and pending registers, then the output register.
// A finished result waits in a pending register while the output register
// is stalled; s_tready drops only when both are full, and requests resume
// the cycle m_tready returns.
// Reset clears the element count and the handshake state; stored entries
// are not cleared and are never shown before being written.
`default_nettype none

`include "indexed_list_insert_erase_unit_macros.svh"

module indexed_list_insert_erase_unit import ilie_pkg::*; #(
    parameter int CAPACITY     = DEF_CAPACITY,
    parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // [6:0] position, [38:7] value, [39] zero
    input  wire logic [S_TDATA_BITS-1:0] s_tdata,
    // [1:0] kind
    input  wire logic [KIND_BITS-1:0]    s_tuser,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // [31:0] read_value, [33:32] status, [40:34] count, [41] is_empty, [47:42] zero
    output logic [M_TDATA_BITS-1:0]      m_tdata
);

    localparam int CNT_BITS = $clog2(CAPACITY + 1);
    localparam int NGROUPS  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    // Request fields
    logic [KIND_BITS-1:0]  s_kind;
    logic [POS_BITS-1:0]   s_position;
    logic [VALUE_BITS-1:0] s_value;
    logic                  s_acc;

    assign s_kind     = s_tuser;
    assign s_position = s_tdata[POS_BITS-1:0];
    assign s_value    = s_tdata[POS_BITS +: VALUE_BITS];
    assign s_acc      = s_tvalid && s_tready;

    // Handshake and count state
    logic [CNT_BITS-1:0]    cnt_reg;
    logic [CNT_BITS-1:0]    cnt_next;
    logic                   pend_reg;
    logic                   pend_next;
    logic [STATUS_BITS-1:0] pend_status_reg;
    logic [STATUS_BITS-1:0] pend_status_next;
    logic [CNT_BITS-1:0]    pend_cnt_reg;
    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic [M_TDATA_BITS-1:0] m_tdata_reg;
    logic                   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = !pend_reg || out_free;

    // Decide the request against the current count
    logic [TGT_BITS-1:0] pos_ext;
    logic [TGT_BITS-1:0] cnt_ext;
    logic                full;
    ctl_t                ctl;

    assign pos_ext = TGT_BITS'(s_position);
    assign cnt_ext = TGT_BITS'(cnt_reg);
    assign full    = (cnt_reg == CNT_BITS'(CAPACITY));

    always_comb begin
        ctl.op           = OP_HOLD;
        ctl.target       = pos_ext;
        pend_status_next = ST_OK;
        cnt_next         = cnt_reg;
        case (s_kind)
            KIND_APPEND: begin
                if (full) begin
                    pend_status_next = ST_FULL;
                end else begin
                    ctl.op     = OP_INSERT;
                    ctl.target = cnt_ext;
                    cnt_next   = cnt_reg + CNT_BITS'(1);
                end
            end
            KIND_INSERT: begin
                if (pos_ext > cnt_ext) begin
                    pend_status_next = ST_BAD_INDEX;
                end else if (full) begin
                    pend_status_next = ST_FULL;
                end else begin
                    ctl.op   = OP_INSERT;
                    cnt_next = cnt_reg + CNT_BITS'(1);
                end
            end
            KIND_READ: begin
                if (pos_ext >= cnt_ext) begin
                    pend_status_next = ST_BAD_INDEX;
                end else begin
                    ctl.op = OP_READ;
                end
            end
            default: begin
                if (pos_ext >= cnt_ext) begin
                    pend_status_next = ST_BAD_INDEX;
                end else begin
                    ctl.op   = OP_REMOVE;
                    cnt_next = cnt_reg - CNT_BITS'(1);
                end
            end
        endcase
        // cells only move on an accepted request
        if (!s_acc) begin
            ctl.op = OP_HOLD;
        end
    end

    // Incoming value kept in ELEMENT_BITS, sign-extended if wider
    logic [ELEMENT_BITS-1:0] wval;

    for (genvar b = 0; b < ELEMENT_BITS; b++) begin : g_wval
        if (b < VALUE_BITS) begin : g_in
            assign wval[b] = s_value[b];
        end else begin : g_ext
            assign wval[b] = s_value[VALUE_BITS-1];
        end
    end

    // Chain of cells
    logic [ELEMENT_BITS-1:0] entry_q [CAPACITY];
    logic [ELEMENT_BITS-1:0] rd_cell [CAPACITY];

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [ELEMENT_BITS-1:0] lower_val;
        logic [ELEMENT_BITS-1:0] upper_val;

        if (k == 0) begin : g_first
            assign lower_val = wval;
        end else begin : g_lower
            assign lower_val = entry_q[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign upper_val = entry_q[k];
        end else begin : g_upper
            assign upper_val = entry_q[k+1];
        end

        ilie_cell #(
            .WIDTH (ELEMENT_BITS),
            .INDEX (k)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .wval      (wval),
            .lower_val (lower_val),
            .upper_val (upper_val),
            .entry     (entry_q[k]),
            .rd_val    (rd_cell[k])
        );
    end

    // Read-out tree, first level: registered OR per group of cells
    logic [ELEMENT_BITS-1:0] part_reg [NGROUPS];

    for (genvar g = 0; g < NGROUPS; g++) begin : g_part
        logic [ELEMENT_BITS-1:0] part_next;

        always_comb begin
            part_next = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                if (g * GROUP_SIZE + j < CAPACITY) begin
                    part_next = part_next | rd_cell[g * GROUP_SIZE + j];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (s_acc) begin
                part_reg[g] <= part_next;
            end
        end
    end

    // Second level: combine the groups
    logic [ELEMENT_BITS-1:0] rd_elem;
    logic [VALUE_BITS-1:0]   rd_value;

    always_comb begin
        rd_elem = '0;
        for (int g = 0; g < NGROUPS; g++) begin
            rd_elem = rd_elem | part_reg[g];
        end
    end

    // Sign-extend from the stored width, cut to the field width
    for (genvar b = 0; b < VALUE_BITS; b++) begin : g_rd
        if (b < ELEMENT_BITS) begin : g_in
            assign rd_value[b] = rd_elem[b];
        end else begin : g_ext
            assign rd_value[b] = rd_elem[ELEMENT_BITS-1];
        end
    end

    // Pending result and output register
    logic [COUNT_BITS-1:0]   out_count;
    logic [M_TDATA_BITS-1:0] m_tdata_next;

    assign out_count = COUNT_BITS'(pend_cnt_reg);

    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[VALUE_BITS-1:0]                   = rd_value;
        m_tdata_next[VALUE_BITS +: STATUS_BITS]        = pend_status_reg;
        m_tdata_next[VALUE_BITS + STATUS_BITS +: COUNT_BITS] = out_count;
        m_tdata_next[VALUE_BITS + STATUS_BITS + COUNT_BITS]  = (pend_cnt_reg == '0);
    end

    always_comb begin
        if (s_acc) begin
            pend_next = 1'b1;
        end else if (out_free) begin
            pend_next = 1'b0;
        end else begin
            pend_next = pend_reg;
        end

        if (pend_reg) begin
            m_tvalid_next = out_free ? 1'b1 : m_tvalid_reg;
        end else begin
            m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
            if (s_acc) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            pend_status_reg <= pend_status_next;
            pend_cnt_reg    <= cnt_next;
        end
        if (pend_reg && out_free) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    `ILIE_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, cnt_reg <= CNT_BITS'(CAPACITY), "count above capacity")
    `ILIE_ASSERT_NEXT(a_count_hold, aclk, aresetn, !s_acc, $stable(cnt_reg), "count moved without request")
    `ILIE_ASSERT_NEXT(a_full_append, aclk, aresetn, s_acc && (s_kind == KIND_APPEND) && full, pend_status_reg == ST_FULL, "append to full list not refused")
    `ILIE_ASSERT_NEXT(a_result_out, aclk, aresetn, pend_reg && out_free, m_tvalid_reg, "pending result not presented")

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ilie_pkg::*;

    localparam int LIST_CAPACITY = DEF_CAPACITY;
    localparam int HOLD_CYCLES   = 300;
    // Leaves a wide margin over the slowest plausible run
    localparam int TIMEOUT_CYCLES = 200_000;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic signed [VALUE_BITS-1:0] read_value;
        logic [STATUS_BITS-1:0]       status;
        logic [COUNT_BITS-1:0]        count;
        logic                         is_empty;
    } list_result_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    wire                     s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata = '0;
    logic [KIND_BITS-1:0]    s_tuser = '0;
    wire                     m_tvalid;
    logic                    m_tready = 1'b0;
    wire  [M_TDATA_BITS-1:0] m_tdata;

    indexed_list_insert_erase_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Own copy of the list contents and length
    logic signed [VALUE_BITS-1:0] list_store [LIST_CAPACITY];
    int list_len = 0;
    int peak_len = 0;

    list_result_t pending_list_results [$];
    idle_mode_t   idle_mode = IDLE_NONE;
    int fail_count = 0;
    int kind_tally [4] = '{default: 0};
    int status_tally [3] = '{default: 0};
    int input_stalls = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    logic hold_active = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("** indexed_list_insert_erase_unit: FAILED **");
        $finish;
    end

    // Apply one request to the list copy and work out its result
    function automatic list_result_t apply_list_request(input logic [KIND_BITS-1:0] kind,
                                                        input logic [POS_BITS-1:0] pos,
                                                        input logic signed [VALUE_BITS-1:0] value);
        list_result_t res;
        res.read_value = '0;
        res.status     = ST_OK;
        case (kind)
            KIND_APPEND: begin
                if (list_len >= LIST_CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    list_store[list_len] = value;
                    list_len++;
                end
            end
            KIND_INSERT: begin
                // index check comes before the full check
                if (pos > list_len) begin
                    res.status = ST_BAD_INDEX;
                end else if (list_len >= LIST_CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (int k = list_len; k > pos; k--)
                        list_store[k] = list_store[k-1];
                    list_store[pos] = value;
                    list_len++;
                end
            end
            KIND_READ: begin
                if (pos >= list_len)
                    res.status = ST_BAD_INDEX;
                else
                    res.read_value = list_store[pos];
            end
            default: begin
                if (pos >= list_len) begin
                    res.status = ST_BAD_INDEX;
                end else begin
                    for (int k = pos; k + 1 < list_len; k++)
                        list_store[k] = list_store[k+1];
                    list_len--;
                end
            end
        endcase
        res.count    = list_len[COUNT_BITS-1:0];
        res.is_empty = (list_len == 0);
        kind_tally[kind]++;
        status_tally[res.status]++;
        if (list_len > peak_len)
            peak_len = list_len;
        return res;
    endfunction

    // Mostly uniform values, with the extremes mixed in
    function automatic logic signed [VALUE_BITS-1:0] random_value();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Offer one request, hold it until taken, then record its expected result
    task automatic issue_request(input logic [KIND_BITS-1:0] kind,
                                 input logic [POS_BITS-1:0] pos,
                                 input logic signed [VALUE_BITS-1:0] value);
        int idle_pct;
        idle_pct = (idle_mode == IDLE_SENDER) ? 86 : (idle_mode == IDLE_BOTH) ? 17 : 0;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, value, pos};
        do @(posedge aclk); while (!s_tready);
        pending_list_results.push_back(apply_list_request(kind, pos, value));
    endtask

    // Stop offering and wait until every result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_list_results.size() != 0)
            @(posedge aclk);
    endtask

    // Long receiver hold-off, counted in cycles
    always @(posedge aclk) begin : hold_count
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left--;
        end
        hold_active <= (hold_left > 0);
    end

    // Result check and receiver stalls
    always @(posedge aclk) begin : result_check
        list_result_t got, want;
        int stall_pct;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (s_tvalid && !s_tready)
                input_stalls++;
            if (m_tvalid && m_tready) begin
                got.read_value = m_tdata[31:0];
                got.status     = m_tdata[33:32];
                got.count      = m_tdata[40:34];
                got.is_empty   = m_tdata[41];
                if (pending_list_results.size() == 0) begin
                    $error("result with no request outstanding: tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    want = pending_list_results.pop_front();
                    if (got.read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               want.read_value, got.read_value);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, got.count);
                        fail_count++;
                    end
                    if (got.is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0d, got %0d",
                               want.is_empty, got.is_empty);
                        fail_count++;
                    end
                end
            end
            stall_pct = (idle_mode == IDLE_RECEIVER) ? 86 : (idle_mode == IDLE_BOTH) ? 17 : 0;
            if (hold_active) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Empty-list errors, edge positions, extreme values, shifts both ways
    task automatic test_directed();
        idle_mode = IDLE_NONE;
        issue_request(KIND_READ, 7'd0, 32'sd0);
        issue_request(KIND_REMOVE, 7'd0, 32'sd0);
        issue_request(KIND_INSERT, 7'd1, 32'sd5);
        issue_request(KIND_INSERT, 7'd0, 32'sh8000_0000);
        issue_request(KIND_APPEND, 7'd0, 32'sh7fff_ffff);
        issue_request(KIND_APPEND, 7'd127, -32'sd1);
        issue_request(KIND_INSERT, 7'd3, 32'sd0);
        issue_request(KIND_INSERT, 7'd1, 32'sd12345);
        issue_request(KIND_INSERT, 7'd0, 32'sha5a5_a5a5);
        for (int p = 0; p < 6; p++)
            issue_request(KIND_READ, p[POS_BITS-1:0], 32'sd0);
        issue_request(KIND_READ, 7'd6, 32'sd0);
        issue_request(KIND_READ, 7'd127, 32'sh7fff_ffff);
        issue_request(KIND_REMOVE, 7'd127, 32'sd0);
        issue_request(KIND_REMOVE, 7'd6, 32'sd0);
        issue_request(KIND_INSERT, 7'd127, 32'sd9);
        issue_request(KIND_REMOVE, 7'd2, 32'sd0);
        issue_request(KIND_REMOVE, 7'd0, 32'sd0);
        issue_request(KIND_REMOVE, 7'd3, 32'sd0);
        issue_request(KIND_READ, 7'd0, 32'sd0);
        wait_drained();
    endtask

    // Fill to capacity, hit every full case, then empty the list again
    task automatic test_full_list();
        idle_mode = IDLE_BOTH;
        while (list_len < LIST_CAPACITY)
            issue_request(KIND_APPEND, POS_BITS'($urandom_range(127)), random_value());
        issue_request(KIND_APPEND, 7'd0, 32'sd1);
        issue_request(KIND_INSERT, 7'd64, 32'sd2);
        issue_request(KIND_INSERT, 7'd65, 32'sd3);
        issue_request(KIND_INSERT, 7'd127, 32'sd4);
        issue_request(KIND_INSERT, 7'd0, 32'sd5);
        issue_request(KIND_READ, 7'd63, 32'sd0);
        issue_request(KIND_READ, 7'd64, 32'sd0);
        issue_request(KIND_REMOVE, 7'd0, 32'sd0);
        issue_request(KIND_INSERT, 7'd0, random_value());
        issue_request(KIND_REMOVE, 7'd63, 32'sd0);
        issue_request(KIND_INSERT, 7'd63, random_value());
        while (list_len > 0)
            issue_request(KIND_REMOVE, POS_BITS'($urandom_range(list_len - 1)),
                          random_value());
        issue_request(KIND_REMOVE, 7'd0, 32'sd0);
        wait_drained();
    endtask

    // Receiver holds off while requests keep coming, so the input backs up
    task automatic test_backpressure();
        idle_mode = IDLE_NONE;
        hold_requests++;
        for (int i = 0; i < 40; i++) begin
            if (i % 3 == 2 && list_len > 0)
                issue_request(KIND_READ, POS_BITS'($urandom_range(list_len - 1)), 32'sd0);
            else
                issue_request(KIND_INSERT, POS_BITS'($urandom_range(list_len)),
                              random_value());
        end
        wait_drained();
    endtask

    // Random requests that drift the length towards a moving target level
    task automatic run_random_phase(input idle_mode_t mode, input int n_items);
        int target;
        int r;
        logic [KIND_BITS-1:0] kind;
        logic [POS_BITS-1:0]  pos;
        idle_mode = mode;
        target = 0;
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0)
                target = $urandom_range(LIST_CAPACITY);
            r = $urandom_range(99);
            if (r < 10) begin
                // noise: any kind, any position
                kind = KIND_BITS'($urandom_range(3));
                pos  = POS_BITS'($urandom_range(127));
            end else if (r < 30) begin
                kind = KIND_READ;
                pos  = POS_BITS'((list_len > 0) ? $urandom_range(list_len - 1)
                                                : $urandom_range(127));
            end else if (list_len < target || $urandom_range(3) == 0) begin
                if ($urandom_range(1)) begin
                    kind = KIND_APPEND;
                    pos  = POS_BITS'($urandom_range(127));
                end else begin
                    kind = KIND_INSERT;
                    pos  = POS_BITS'($urandom_range(list_len));
                end
            end else begin
                kind = KIND_REMOVE;
                pos  = POS_BITS'((list_len > 0) ? $urandom_range(list_len - 1)
                                                : $urandom_range(127));
            end
            issue_request(kind, pos, random_value());
        end
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_full_list();
        test_backpressure();
        run_random_phase(IDLE_NONE, 140);
        run_random_phase(IDLE_SENDER, 140);
        run_random_phase(IDLE_RECEIVER, 140);
        run_random_phase(IDLE_BOTH, 140);

        // let any stray result surface
        repeat (10) @(posedge aclk);
        if (pending_list_results.size() != 0) begin
            $error("%0d results never arrived", pending_list_results.size());
            fail_count++;
        end

        $display("Covered %0d requests: %0d append, %0d insert, %0d read, %0d remove",
                 kind_tally[0] + kind_tally[1] + kind_tally[2] + kind_tally[3],
                 kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3]);
        $display("Outcomes %0d ok / %0d bad index / %0d full, peak length %0d,",
                 status_tally[0], status_tally[1], status_tally[2], peak_len);
        $display("%0d input stall cycles", input_stalls);
        if (fail_count == 0) begin
            $display("** indexed_list_insert_erase_unit: PASSED **");
        end else begin
            $display("** indexed_list_insert_erase_unit: FAILED **");
        end
        $finish;
    end

endmodule

FILE: indexed_list_insert_erase_unit.f
+incdir+sv
sv/ilie_pkg.sv
sv/ilie_cell.sv
sv/indexed_list_insert_erase_unit.sv
tb/testbench.sv
